/* sv/ppd_pkg.sv */
package ppd_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PWM_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDUP    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PUSH_STEP = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EASE_STEP = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 4'd7;

  localparam logic [7:0]  RST_GAIN_P    = 8'd2;
  localparam logic [7:0]  RST_GAIN_I    = 8'd1;
  localparam logic [7:0]  RST_GAIN_D    = 8'd0;
  localparam logic [14:0] RST_WINDUP    = 15'd200;
  localparam logic [9:0]  RST_PUSH_STEP = 10'd25;
  localparam logic [9:0]  RST_EASE_STEP = 10'd50;
  localparam logic [9:0]  RST_CEILING   = 10'd450;
  localparam logic [15:0] RST_TARGET    = 16'd0;

  // blowoff threshold is this multiple of the target count
  localparam logic [26:0] BLOW_MULT = 27'd1000;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_BLOW = 2'd1,
    ACT_EASE = 2'd2
  } ppd_action_t;

  typedef struct packed {
    logic [7:0]       gain_p;
    logic [7:0]       gain_i;
    logic [7:0]       gain_d;
    logic [14:0]      windup_limit;
    logic [PWM_W-1:0] push_step_max;
    logic [PWM_W-1:0] ease_step_max;
    logic [PWM_W-1:0] pwm_ceiling;
    logic [15:0]      target_count;
  } ppd_cfg_t;

  typedef struct packed {
    logic signed [15:0] err;
    logic signed [16:0] diff;
    logic signed [15:0] integ;
    logic [31:0]        infused;
  } ppd_s1_t;

  typedef struct packed {
    logic [31:0]      corr;
    ppd_action_t      action;
    logic [PWM_W-1:0] step;
    logic [15:0]      integ;
    logic [31:0]      infused;
  } ppd_s3_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm;
    ppd_action_t      action;
    logic [31:0]      corr;
    logic [15:0]      integ;
    logic [31:0]      infused;
  } ppd_out_t;

endpackage

/* sv/ppd_integ.sv */
module ppd_integ (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [15:0] err,
  input  ppd_pkg::ppd_cfg_t  cfg,
  output logic               out_valid,
  output ppd_pkg::ppd_s1_t   out
);
  import ppd_pkg::*;

  logic signed [16:0] integral_acc;
  logic signed [15:0] last_error;
  logic [31:0]        infused_total;

  logic signed [17:0] sum;
  logic signed [17:0] lim;
  logic signed [17:0] clamped;
  logic [31:0]        infused_next;
  logic signed [16:0] diff;

  assign sum = {integral_acc[16], integral_acc} + {{2{err[15]}}, err};
  assign lim = $signed({3'b000, cfg.windup_limit});

  always_comb begin
    priority if (sum > lim) begin
      clamped = lim;
    end else if (sum < -lim) begin
      clamped = -lim;
    end else begin
      clamped = sum;
    end
  end

  assign diff = {err[15], err} - {last_error[15], last_error};
  assign infused_next = infused_total - {{16{err[15]}}, err} + {16'd0, cfg.target_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc  <= '0;
      last_error    <= '0;
      infused_total <= '0;
      out_valid     <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        integral_acc  <= clamped[16:0];
        last_error    <= err;
        infused_total <= infused_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out.err     <= err;
      out.diff    <= diff;
      out.integ   <= clamped[15:0];
      out.infused <= infused_next;
    end
  end

endmodule

/* sv/ppd_corr.sv */
module ppd_corr (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  ppd_pkg::ppd_s1_t  in,
  input  ppd_pkg::ppd_cfg_t cfg,
  output logic              out_valid,
  output ppd_pkg::ppd_s3_t  out
);
  import ppd_pkg::*;

  // product stage
  logic               v2;
  logic signed [24:0] prod_p;
  logic signed [25:0] prod_d;
  logic signed [24:0] prod_i;
  logic [26:0]        thresh;
  logic [15:0]        integ2;
  logic [31:0]        infused2;

  // decision stage
  logic signed [27:0] corr;
  logic signed [27:0] corr_neg;
  logic signed [27:0] thresh_s;
  ppd_action_t        action;
  logic [PWM_W-1:0]   step;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      prod_p   <= $signed({1'b0, cfg.gain_p}) * $signed(in.err);
      prod_d   <= $signed({1'b0, cfg.gain_d}) * $signed(in.diff);
      prod_i   <= $signed({1'b0, cfg.gain_i}) * $signed(in.integ);
      thresh   <= {11'd0, cfg.target_count} * BLOW_MULT;
      integ2   <= in.integ;
      infused2 <= in.infused;
    end
  end

  assign corr = {{3{prod_p[24]}}, prod_p} + {{2{prod_d[25]}}, prod_d}
              + {{3{prod_i[24]}}, prod_i};
  assign corr_neg = -corr;
  assign thresh_s = $signed({1'b0, thresh});

  always_comb begin
    priority if (corr[27]) begin
      action = ACT_PUSH;
      step   = (corr_neg > $signed({18'd0, cfg.push_step_max})) ?
               cfg.push_step_max : corr_neg[PWM_W-1:0];
    end else if (corr > thresh_s) begin
      action = ACT_BLOW;
      step   = '0;
    end else begin
      action = ACT_EASE;
      step   = (corr > $signed({18'd0, cfg.ease_step_max})) ?
               cfg.ease_step_max : corr[PWM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2) begin
      out.corr    <= {{4{corr[27]}}, corr};
      out.action  <= action;
      out.step    <= step;
      out.integ   <= integ2;
      out.infused <= infused2;
    end
  end

endmodule

/* sv/ppd_drive.sv */
module ppd_drive (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  ppd_pkg::ppd_s3_t  in,
  input  ppd_pkg::ppd_cfg_t cfg,
  output logic              out_valid,
  output ppd_pkg::ppd_out_t out
);
  import ppd_pkg::*;

  logic [PWM_W-1:0] pwm_reg;
  logic [PWM_W-1:0] pwm_next;
  logic [PWM_W:0]   pwm_up;

  assign pwm_up = {1'b0, pwm_reg} + {1'b0, in.step};

  always_comb begin
    unique case (in.action)
      ACT_PUSH: begin
        pwm_next = (pwm_up > {1'b0, cfg.pwm_ceiling}) ? cfg.pwm_ceiling : pwm_up[PWM_W-1:0];
      end
      ACT_BLOW: begin
        pwm_next = '0;
      end
      ACT_EASE: begin
        pwm_next = (pwm_reg >= in.step) ? (pwm_reg - in.step) : '0;
      end
      default: begin
        pwm_next = pwm_reg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_reg   <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        pwm_reg <= pwm_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out.pwm     <= pwm_next;
      out.action  <= in.action;
      out.corr    <= in.corr;
      out.integ   <= in.integ;
      out.infused <= in.infused;
    end
  end

endmodule

/* sv/pid_pump_drive_controller.sv */
// channel  | dir | handshake           | payload
// ---------+-----+---------------------+-----------------------------------------
// s_axis   | in  | s_tvalid / s_tready | s_tdata: flow_error
// m_axis   | out | m_tvalid / m_tready | m_tdata: pwm, correction, integral, infused
//          |     |                     | m_tuser: drive_action
// cfg      | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; every stage is registered.
// The integrator, the PWM register and the infused total each close their loop
// within one stage, so back-to-back words need no wait.
// Synchronous reset clears the state, config returns to defaults.
// A stalled output holds the whole pipeline and drops s_tready.
module pid_pump_drive_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // [15:0] flow_error
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [9:0] pwm_level, [41:10] correction_value, [57:42] integral_value,
  // [89:58] infused_count, [95:90] zero
  output logic [95:0]                    m_tdata,
  output logic [1:0]                     m_tuser,   // [1:0] drive_action
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppd_pkg::*;

  ppd_cfg_t           cfg;
  logic               adv;
  logic               v0;
  logic signed [15:0] err0;
  logic               v1;
  ppd_s1_t            s1;
  logic               v3;
  ppd_s3_t            s3;
  ppd_out_t           res;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p        <= RST_GAIN_P;
      cfg.gain_i        <= RST_GAIN_I;
      cfg.gain_d        <= RST_GAIN_D;
      cfg.windup_limit  <= RST_WINDUP;
      cfg.push_step_max <= RST_PUSH_STEP;
      cfg.ease_step_max <= RST_EASE_STEP;
      cfg.pwm_ceiling   <= RST_CEILING;
      cfg.target_count  <= RST_TARGET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAIN_P:    cfg.gain_p        <= cfg_data[7:0];
        CFG_GAIN_I:    cfg.gain_i        <= cfg_data[7:0];
        CFG_GAIN_D:    cfg.gain_d        <= cfg_data[7:0];
        CFG_WINDUP:    cfg.windup_limit  <= cfg_data[14:0];
        CFG_PUSH_STEP: cfg.push_step_max <= cfg_data[PWM_W-1:0];
        CFG_EASE_STEP: cfg.ease_step_max <= cfg_data[PWM_W-1:0];
        CFG_CEILING:   cfg.pwm_ceiling   <= cfg_data[PWM_W-1:0];
        CFG_TARGET:    cfg.target_count  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_tvalid) begin
      err0 <= $signed(s_tdata);
    end
  end

  ppd_integ u_integ (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v0),
    .err       (err0),
    .cfg       (cfg),
    .out_valid (v1),
    .out       (s1)
  );

  ppd_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v1),
    .in        (s1),
    .cfg       (cfg),
    .out_valid (v3),
    .out       (s3)
  );

  ppd_drive u_drive (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v3),
    .in        (s3),
    .cfg       (cfg),
    .out_valid (m_tvalid),
    .out       (res)
  );

  assign m_tdata = {6'd0, res.infused, res.integ, res.corr, res.pwm};
  assign m_tuser = res.action;

endmodule

/* sv/ppd_check.sv */
module ppd_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import ppd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  a_push_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[41] == (m_tuser == ACT_PUSH)))
    else $error("push action does not match negative correction");

  a_blow_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ACT_BLOW |-> m_tdata[9:0] == '0)
    else $error("blowoff with nonzero pwm");

  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[57:42] != 16'h8000)
    else $error("integral outside clamp range");

endmodule

bind pid_pump_drive_controller ppd_check u_check (.*);
